// ===== src/lsf_pkg.sv =====
// Package for the line substring filter: action and rule-kind codes and field widths.
// No dependencies; imported by line_substring_filter.
`timescale 1ns / 1ps

package lsf_pkg;

  // Field widths of one input item.
  localparam int ACTION_W = 2;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int POS_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int PLEN_W   = 6;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_LEN = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd3;

  // Rule kinds.
  localparam logic [KIND_W-1:0] KIND_INCLUDE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXCLUDE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIGHLIGHT = 2'd2;

endpackage

// ===== src/line_substring_filter.sv =====
// Top level of the line substring filter: window, rule memory, slot sweep sequencer.
// Depends on lsf_pkg for action codes, rule kinds and field widths.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) carries one action per transfer: clear all
// rules, write one pattern byte, set a slot length, or one text byte. Rule actions
// finish in the idle state. A text byte first goes into the window, then every
// slot in turn passes through the shared compare unit, which reads one pattern row
// from the rule memory and checks it against the window; a drain step empties the
// compare stage and a final step forms the result. in_ready is high only while the
// sequencer is idle. On the last byte of a line the result (drop_line, highlight) is
// placed in the output register and offered on out_valid/out_ready; the block goes
// on taking items while it waits, and stalls in its final step only if a second
// result is ready before the first was taken. Reset clears slot lengths, match
// flags, the window and the line position; pattern bytes are undefined until
// written and need no clearing pass.
module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int INCLUDE_SLOTS   = 8,
  parameter int EXCLUDE_SLOTS   = 8,
  parameter int HIGHLIGHT_SLOTS = 8,
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [KIND_W-1:0]   rule_kind,
  input  logic [SLOT_W-1:0]   rule_slot,
  input  logic [POS_W-1:0]    pattern_pos,
  input  logic [BYTE_W-1:0]   pattern_byte,
  input  logic [PLEN_W-1:0]   pattern_len,
  input  logic [BYTE_W-1:0]   text_byte,
  input  logic                line_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                drop_line,
  output logic                highlight
);

  localparam int TOTAL_SLOTS = INCLUDE_SLOTS + EXCLUDE_SLOTS + HIGHLIGHT_SLOTS;
  localparam int FLAT_W      = $clog2(TOTAL_SLOTS);
  localparam int LEN_W       = $clog2(MAX_PATTERN_LEN + 1);
  localparam int IDX_W       = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int ROW_W       = MAX_PATTERN_LEN * BYTE_W;
  localparam int ARITH_W     = (LEN_W > 8 ? LEN_W : 8) + 2;

  localparam logic [FLAT_W-1:0]  LAST_SLOT  = FLAT_W'(TOTAL_SLOTS - 1);
  localparam logic [FLAT_W:0]    EXC_BASE   = (FLAT_W + 1)'(INCLUDE_SLOTS);
  localparam logic [FLAT_W:0]    HL_BASE    = (FLAT_W + 1)'(INCLUDE_SLOTS + EXCLUDE_SLOTS);
  localparam logic [LEN_W-1:0]   MAX_LEN    = LEN_W'(MAX_PATTERN_LEN);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state;
  logic [FLAT_W-1:0] issue_slot;
  logic [FLAT_W-1:0] cmp_slot;
  logic              cmp_vld;
  logic              line_end_q;

  // Rule state and text window.
  logic [ROW_W-1:0]  pattern_mem [TOTAL_SLOTS];
  logic [ROW_W-1:0]  row_q;
  logic [LEN_W-1:0]  slot_lengths [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] slot_found;
  logic [BYTE_W-1:0] recent_bytes [MAX_PATTERN_LEN];
  logic [LEN_W-1:0]  bytes_in_line;

  // Per-line accumulators gathered during the sweep.
  logic inc_active;
  logic inc_hit;
  logic exc_hit;
  logic hl_hit;

  logic              in_xfer;
  logic              flat_ok;
  logic [FLAT_W-1:0] flat_idx;
  logic              pos_ok;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  cmp_len;
  logic              mismatch;
  logic              match;
  logic [FLAT_W:0]   cmp_slot_ext;
  logic              result_load;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // A finished line loads the result register once it is free or being emptied.
  assign result_load = (state == ST_FINISH) && line_end_q && (!out_valid || out_ready);

  // Map (kind, slot) to a flat slot index, flagging pairs that name no slot.
  always_comb begin
    logic [ARITH_W-1:0] slot_ext;
    slot_ext = ARITH_W'(rule_slot);
    flat_ok  = 1'b0;
    flat_idx = '0;
    unique case (rule_kind)
      KIND_INCLUDE: begin
        flat_ok  = slot_ext < ARITH_W'(INCLUDE_SLOTS);
        flat_idx = FLAT_W'(slot_ext);
      end
      KIND_EXCLUDE: begin
        flat_ok  = slot_ext < ARITH_W'(EXCLUDE_SLOTS);
        flat_idx = FLAT_W'(slot_ext + ARITH_W'(INCLUDE_SLOTS));
      end
      KIND_HIGHLIGHT: begin
        flat_ok  = slot_ext < ARITH_W'(HIGHLIGHT_SLOTS);
        flat_idx = FLAT_W'(slot_ext + ARITH_W'(INCLUDE_SLOTS + EXCLUDE_SLOTS));
      end
      default: begin
        flat_ok  = 1'b0;
        flat_idx = '0;
      end
    endcase
  end

  // Position range check and length saturation.
  assign pos_ok  = ARITH_W'(pattern_pos) < ARITH_W'(MAX_PATTERN_LEN);
  assign len_sat = (ARITH_W'(pattern_len) > ARITH_W'(MAX_PATTERN_LEN)) ? MAX_LEN
                                                                       : LEN_W'(pattern_len);

  // Rule memory: one row per slot, byte-wide writes, registered row read.
  always_ff @(posedge clk) begin
    if (in_xfer && action == ACT_WRITE && flat_ok && pos_ok) begin
      pattern_mem[flat_idx][IDX_W'(pattern_pos)*BYTE_W +: BYTE_W] <= pattern_byte;
    end
    row_q <= pattern_mem[issue_slot];
  end

  // Shared compare unit: one slot's pattern against the newest window bytes.
  assign cmp_len = slot_lengths[cmp_slot];
  always_comb begin
    logic [ARITH_W-1:0] idx_wide;
    mismatch = 1'b0;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      idx_wide = ARITH_W'(cmp_len) - ARITH_W'(1) - ARITH_W'(j);
      if (ARITH_W'(j) < ARITH_W'(cmp_len)) begin
        if (row_q[j*BYTE_W +: BYTE_W] != recent_bytes[IDX_W'(idx_wide)]) begin
          mismatch = 1'b1;
        end
      end
    end
  end
  assign match = (cmp_len != '0) && (cmp_len <= bytes_in_line) && !mismatch;
  assign cmp_slot_ext = (FLAT_W + 1)'(cmp_slot);

  // Sequencer, rule updates, window and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      issue_slot    <= '0;
      cmp_slot      <= '0;
      cmp_vld       <= 1'b0;
      line_end_q    <= 1'b0;
      slot_found    <= '0;
      bytes_in_line <= '0;
      inc_active    <= 1'b0;
      inc_hit       <= 1'b0;
      exc_hit       <= 1'b0;
      hl_hit        <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        slot_lengths[i] <= '0;
      end
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        recent_bytes[i] <= '0;
      end
    end else begin
      // Result valid: set by a finished line, cleared by an output transfer.
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Compare stage: update the slot flag and the per-kind summaries.
      cmp_vld <= (state == ST_SWEEP);
      if (cmp_vld) begin
        slot_found[cmp_slot] <= slot_found[cmp_slot] | match;
        if (cmp_slot_ext < EXC_BASE) begin
          if (cmp_len != '0) inc_active <= 1'b1;
          if (slot_found[cmp_slot] || match) inc_hit <= 1'b1;
        end else if (cmp_slot_ext < HL_BASE) begin
          if (slot_found[cmp_slot] || match) exc_hit <= 1'b1;
        end else begin
          if (slot_found[cmp_slot] || match) hl_hit <= 1'b1;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (action)
              ACT_CLEAR: begin
                slot_found <= '0;
                for (int i = 0; i < TOTAL_SLOTS; i++) begin
                  slot_lengths[i] <= '0;
                end
              end
              ACT_WRITE: begin
                // The memory write is done in the memory block.
              end
              ACT_SET_LEN: begin
                if (flat_ok) begin
                  slot_lengths[flat_idx] <= len_sat;
                  slot_found[flat_idx]   <= 1'b0;
                end
              end
              ACT_TEXT: begin
                for (int i = MAX_PATTERN_LEN - 1; i > 0; i--) begin
                  recent_bytes[i] <= recent_bytes[i-1];
                end
                recent_bytes[0] <= text_byte;
                if (bytes_in_line < MAX_LEN) begin
                  bytes_in_line <= bytes_in_line + LEN_W'(1);
                end
                line_end_q <= line_end;
                inc_active <= 1'b0;
                inc_hit    <= 1'b0;
                exc_hit    <= 1'b0;
                hl_hit     <= 1'b0;
                issue_slot <= '0;
                state      <= ST_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          cmp_slot <= issue_slot;
          if (issue_slot == LAST_SLOT) begin
            state <= ST_DRAIN;
          end else begin
            issue_slot <= issue_slot + FLAT_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!line_end_q) begin
            state <= ST_IDLE;
          end else if (result_load) begin
            drop_line     <= (inc_active && !inc_hit) || exc_hit;
            highlight     <= hl_hit;
            slot_found    <= '0;
            bytes_in_line <= '0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
              recent_bytes[i] <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A new result appears only out of the final step of a line.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside the final step");

  // The compare stage is empty whenever the block takes a new item.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmp_vld)
    else $error("compare stage busy while ready");

  // A text byte always starts a sweep.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && action == ACT_TEXT) |=> state == ST_SWEEP && issue_slot == '0)
    else $error("text byte did not start a sweep");

  // A waiting result is never overwritten before it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(drop_line) && $stable(highlight))
    else $error("pending result changed");

endmodule
